/* sv/rstb_pkg.sv */
// shared types and constants of the relay safety timer bank
package rstb_pkg;

    // largest bank the status fields can report
    localparam int unsigned MAX_RELAYS = 4;

    localparam int unsigned MS_PER_SEC = 1000;
    // floor(x / 1000) == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x
    localparam logic [28:0] DIV_MAGIC  = 29'h1062_4DD3;
    localparam int unsigned DIV_SHIFT  = 38;
    localparam logic [16:0] ON_SEC_MAX = 17'h1_FFFF;
    localparam logic [15:0] ACT_MAX    = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_TICK   = 3'd0,
        REQ_ON     = 3'd1,
        REQ_OFF    = 3'd2,
        REQ_TOGGLE = 3'd3,
        REQ_STOP   = 3'd4,
        REQ_CLEAR  = 3'd5,
        REQ_DAILY  = 3'd6,
        REQ_QUERY  = 3'd7
    } t_req_op;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_MIN_OFF = 2'd1,
        CAUSE_DAILY   = 2'd2,
        CAUSE_MAX_ON  = 2'd3
    } t_cause;

    typedef enum logic [2:0] {
        CFG_RELAY_COUNT  = 3'd0,
        CFG_ENABLED_MASK = 3'd1,
        CFG_ACTIVE_LOW   = 3'd2,
        CFG_MAX_ON       = 3'd3,
        CFG_MIN_OFF      = 3'd4,
        CFG_DAILY_LIMIT  = 3'd5
    } t_cfg_reg;

    // request payload
    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  relay_index;
        logic [15:0] duration_sec;
        logic [31:0] now_ms;
    } t_req;

    // response payload
    typedef struct packed {
        logic        accepted;
        logic [3:0]  relay_on_mask;
        logic [3:0]  pin_mask;
        logic [3:0]  lockout_mask;
        logic [1:0]  lock_code;
        logic [15:0] switch_on_count;
        logic [16:0] on_time_today_sec;
    } t_rsp;

    // per-channel control from the top level
    typedef struct packed {
        logic        commit;
        t_req_op     op;
        logic        addressed;
        logic        in_cnt;
        logic [31:0] now;
        logic [15:0] dur;
    } t_lane_ctl;

    // per-channel settings
    typedef struct packed {
        logic        enabled;
        logic [15:0] max_on;
        logic [15:0] min_off;
        logic [15:0] limit;
    } t_lane_cfg;

    // per-channel state after the request
    typedef struct packed {
        logic        on;
        logic        locked;
        t_cause      cause;
        logic [15:0] act;
        logic [16:0] on_sec;
        logic        ok;
    } t_lane_stat;

endpackage

/* sv/rstb_stream_if.sv */
// valid/ready stream interface carrying one payload type
interface rstb_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/rstb_lane.sv */
// one relay channel: state registers and the per-request update
module rstb_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rstb_pkg::t_lane_ctl  i_ctl,
    input  rstb_pkg::t_lane_cfg  i_cfg,
    output rstb_pkg::t_lane_stat o_stat
);

    logic                 r_on, n_on;
    logic [31:0]          r_start, n_start;
    logic [31:0]          r_off_stamp, n_off_stamp;
    logic                 r_off_valid, n_off_valid;
    logic [25:0]          r_dl_ms, n_dl_ms;
    logic                 r_dl_valid, n_dl_valid;
    logic [16:0]          r_on_sec, n_on_sec;
    logic [15:0]          r_act, n_act;
    logic                 r_locked, n_locked;
    rstb_pkg::t_cause     r_cause, n_cause;

    logic [31:0] w_elapsed;
    logic [31:0] w_off_since;
    logic [60:0] w_prod;
    logic [22:0] w_secs_raw;
    logic [16:0] w_secs;
    logic [17:0] w_sum;
    logic [16:0] w_on_sec_add;
    logic [25:0] w_max_ms;
    logic [25:0] w_min_ms;
    logic [15:0] w_dur_req;
    logic [15:0] w_dur_eff;
    logic [25:0] w_dur_ms;
    logic        w_minoff_hit;
    logic        w_limit_hit;
    logic        w_on_ok;
    logic        w_do_try;
    logic        w_do_off;
    logic        w_do_lock3;
    logic        w_do_unlock;
    logic        w_do_daily;

    // elapsed times and whole seconds on
    assign w_elapsed   = i_ctl.now - r_start;
    assign w_off_since = i_ctl.now - r_off_stamp;
    assign w_prod      = 61'(w_elapsed) * 61'(rstb_pkg::DIV_MAGIC);
    assign w_secs_raw  = w_prod[60:rstb_pkg::DIV_SHIFT];
    assign w_secs      = (|w_secs_raw[22:17]) ? rstb_pkg::ON_SEC_MAX : w_secs_raw[16:0];
    assign w_sum       = 18'(r_on_sec) + 18'(w_secs);
    assign w_on_sec_add = w_sum[17] ? rstb_pkg::ON_SEC_MAX : w_sum[16:0];

    // limits scaled to milliseconds
    assign w_max_ms  = 26'(i_cfg.max_on) * 26'(rstb_pkg::MS_PER_SEC);
    assign w_min_ms  = 26'(i_cfg.min_off) * 26'(rstb_pkg::MS_PER_SEC);
    assign w_dur_req = (i_ctl.op == rstb_pkg::REQ_TOGGLE) ? 16'd0 : i_ctl.dur;
    assign w_dur_eff = (w_dur_req != 16'd0) ? w_dur_req : i_cfg.max_on;
    assign w_dur_ms  = 26'(w_dur_eff) * 26'(rstb_pkg::MS_PER_SEC);

    // turn-on checks
    assign w_minoff_hit = r_off_valid && (i_cfg.min_off != 16'd0)
                          && (w_off_since < 32'(w_min_ms));
    assign w_limit_hit  = (i_cfg.limit != 16'd0) && (r_on_sec >= 17'(i_cfg.limit));
    assign w_on_ok      = i_cfg.enabled
                          && (r_on || (!r_locked && !w_minoff_hit && !w_limit_hit));

    // decode request into actions
    always_comb begin
        w_do_try    = 1'b0;
        w_do_off    = 1'b0;
        w_do_lock3  = 1'b0;
        w_do_unlock = 1'b0;
        w_do_daily  = 1'b0;
        unique case (i_ctl.op)
            rstb_pkg::REQ_TICK: begin
                if (i_ctl.in_cnt && r_on) begin
                    if (r_dl_valid && (w_elapsed >= 32'(r_dl_ms))) begin
                        w_do_off = 1'b1;
                    end else if ((i_cfg.max_on != 16'd0) && (w_elapsed >= 32'(w_max_ms))) begin
                        w_do_off   = 1'b1;
                        w_do_lock3 = 1'b1;
                    end
                end
            end
            rstb_pkg::REQ_ON: begin
                w_do_try = i_ctl.addressed && i_ctl.in_cnt;
            end
            rstb_pkg::REQ_OFF: begin
                w_do_off = i_ctl.addressed && i_ctl.in_cnt;
            end
            rstb_pkg::REQ_TOGGLE: begin
                w_do_off = i_ctl.addressed && i_ctl.in_cnt && r_on;
                w_do_try = i_ctl.addressed && i_ctl.in_cnt && !r_on;
            end
            rstb_pkg::REQ_STOP: begin
                w_do_off = i_ctl.in_cnt;
            end
            rstb_pkg::REQ_CLEAR: begin
                w_do_unlock = i_ctl.addressed;
            end
            rstb_pkg::REQ_DAILY: begin
                w_do_daily = i_ctl.in_cnt;
            end
            rstb_pkg::REQ_QUERY: begin
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_on        = r_on;
        n_start     = r_start;
        n_off_stamp = r_off_stamp;
        n_off_valid = r_off_valid;
        n_dl_ms     = r_dl_ms;
        n_dl_valid  = r_dl_valid;
        n_on_sec    = r_on_sec;
        n_act       = r_act;
        n_locked    = r_locked;
        n_cause     = r_cause;
        if (i_ctl.commit) begin
            if (w_do_off && r_on) begin
                n_on_sec    = w_on_sec_add;
                n_on        = 1'b0;
                n_off_stamp = i_ctl.now;
                n_off_valid = 1'b1;
                n_dl_valid  = 1'b0;
                n_dl_ms     = '0;
            end
            if (w_do_lock3) begin
                n_locked = 1'b1;
                n_cause  = rstb_pkg::CAUSE_MAX_ON;
            end
            if (w_do_try && i_cfg.enabled && !r_on && !r_locked) begin
                priority if (w_minoff_hit) begin
                    n_locked = 1'b1;
                    n_cause  = rstb_pkg::CAUSE_MIN_OFF;
                end else if (w_limit_hit) begin
                    n_locked = 1'b1;
                    n_cause  = rstb_pkg::CAUSE_DAILY;
                end else begin
                    n_on       = 1'b1;
                    n_start    = i_ctl.now;
                    n_act      = (r_act != rstb_pkg::ACT_MAX) ? r_act + 16'd1 : r_act;
                    n_dl_valid = (w_dur_eff != 16'd0);
                    n_dl_ms    = (w_dur_eff != 16'd0) ? w_dur_ms : '0;
                end
            end
            if (w_do_unlock || w_do_daily) begin
                n_locked = 1'b0;
                n_cause  = rstb_pkg::CAUSE_NONE;
            end
            if (w_do_daily) begin
                n_on_sec = '0;
                n_act    = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on        <= 1'b0;
            r_off_valid <= 1'b0;
            r_dl_valid  <= 1'b0;
            r_on_sec    <= '0;
            r_act       <= '0;
            r_locked    <= 1'b0;
            r_cause     <= rstb_pkg::CAUSE_NONE;
        end else begin
            r_on        <= n_on;
            r_off_valid <= n_off_valid;
            r_dl_valid  <= n_dl_valid;
            r_on_sec    <= n_on_sec;
            r_act       <= n_act;
            r_locked    <= n_locked;
            r_cause     <= n_cause;
        end
    end

    // timestamps only matter while their valid flag or the on flag is set
    always_ff @(posedge i_clk) begin
        r_start     <= n_start;
        r_off_stamp <= n_off_stamp;
        r_dl_ms     <= n_dl_ms;
    end

    // state as seen after this request
    always_comb begin
        o_stat.on     = n_on;
        o_stat.locked = n_locked;
        o_stat.cause  = n_cause;
        o_stat.act    = n_act;
        o_stat.on_sec = n_on_sec;
        o_stat.ok     = (i_ctl.op == rstb_pkg::REQ_TOGGLE && r_on) ? 1'b1 : w_on_ok;
    end

    // a relay that is on can never be locked out
    a_on_not_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_on |-> !r_locked)
        else $error("relay on while locked out");

    // lock flag and lock cause move together
    a_cause_matches_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked == (r_cause != rstb_pkg::CAUSE_NONE))
        else $error("lock cause disagrees with lock flag");

    // a running deadline needs the relay on
    a_deadline_needs_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dl_valid |-> r_on)
        else $error("deadline running on an off relay");

endmodule

/* sv/relay_safety_timer_bank_top.sv */
// relay safety timer bank: request/response channels, settings and channel lanes
//
// Requests enter on i_req (valid/ready) and each yields exactly one response on
// o_rsp. A request is captured in an input register, all channels evaluate it in
// parallel once the output register is free or draining, and the response lands
// in an output register; one request per cycle is taken while o_rsp is drained.
// The clock speed is set by the single combinational pass per channel, whose
// longest path is the elapsed-time subtraction, a constant reciprocal multiply
// for seconds and a saturating add. The user must write settings through
// i_cfg_we/i_cfg_idx/i_cfg_data only while no request is in flight; the block
// itself does not enforce this. Synchronous reset clears the settings, turns
// every relay off, clears lockouts and daily counters and empties both
// registers. When the receiver holds o_rsp.ready low, the response is held,
// the input register fills with the next request and then i_req.ready drops.
module relay_safety_timer_bank_top #(
    parameter int unsigned NUM_RELAYS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rstb_stream_if.sink          i_req,
    rstb_stream_if.source        o_rsp,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [63:0]          i_cfg_data
);

    localparam int unsigned NR = rstb_pkg::MAX_RELAYS;

    // settings
    logic [2:0]  r_relay_count;
    logic [3:0]  r_enabled;
    logic [3:0]  r_active_low;
    logic [63:0] r_max_on;
    logic [63:0] r_min_off;
    logic [63:0] r_limit;

    // input and output stages
    logic            r_in_valid;
    rstb_pkg::t_req  r_in;
    logic            r_out_valid;
    rstb_pkg::t_rsp  r_out;
    rstb_pkg::t_rsp  n_out;

    logic                 w_adv;
    rstb_pkg::t_req_op    w_op;
    logic [2:0]           w_cnt;
    logic [3:0]           w_cnt_mask;
    logic [3:0]           w_vmask;
    logic                 w_idx_in_cnt;
    logic                 w_idx_exists;
    logic                 w_ok;
    logic [3:0]           w_onm;
    logic [3:0]           w_lkm;
    rstb_pkg::t_lane_ctl  w_ctl [NR];
    rstb_pkg::t_lane_stat w_stat [NR];

    // settings writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay_count <= '0;
            r_enabled     <= '0;
            r_active_low  <= '0;
            r_max_on      <= '0;
            r_min_off     <= '0;
            r_limit       <= '0;
        end else if (i_cfg_we) begin
            unique case (rstb_pkg::t_cfg_reg'(i_cfg_idx))
                rstb_pkg::CFG_RELAY_COUNT:  r_relay_count <= i_cfg_data[2:0];
                rstb_pkg::CFG_ENABLED_MASK: r_enabled     <= i_cfg_data[3:0];
                rstb_pkg::CFG_ACTIVE_LOW:   r_active_low  <= i_cfg_data[3:0];
                rstb_pkg::CFG_MAX_ON:       r_max_on      <= i_cfg_data;
                rstb_pkg::CFG_MIN_OFF:      r_min_off     <= i_cfg_data;
                rstb_pkg::CFG_DAILY_LIMIT:  r_limit       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // handshake: evaluate when the output register is free or draining
    assign w_adv       = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.payload = r_out;

    // effective channel count and masks
    assign w_cnt   = (r_relay_count > 3'(NUM_RELAYS)) ? 3'(NUM_RELAYS) : r_relay_count;
    assign w_vmask = 4'((5'd1 << NUM_RELAYS) - 5'd1);
    always_comb begin
        for (int k = 0; k < NR; k++) begin
            w_cnt_mask[k] = (3'(k) < w_cnt);
        end
    end

    assign w_op         = rstb_pkg::t_req_op'(r_in.req_type);
    assign w_idx_in_cnt = (3'(r_in.relay_index) < w_cnt);
    assign w_idx_exists = (3'(r_in.relay_index) < 3'(NUM_RELAYS));

    // channel lanes
    for (genvar g = 0; g < NR; g++) begin : g_lane
        always_comb begin
            w_ctl[g].commit    = w_adv;
            w_ctl[g].op        = w_op;
            w_ctl[g].addressed = (r_in.relay_index == 2'(g));
            w_ctl[g].in_cnt    = w_cnt_mask[g];
            w_ctl[g].now       = r_in.now_ms;
            w_ctl[g].dur       = r_in.duration_sec;
        end
        if (g < NUM_RELAYS) begin : g_used
            rstb_pkg::t_lane_cfg w_cfg;
            always_comb begin
                w_cfg.enabled = r_enabled[g];
                w_cfg.max_on  = r_max_on[16*g +: 16];
                w_cfg.min_off = r_min_off[16*g +: 16];
                w_cfg.limit   = r_limit[16*g +: 16];
            end
            rstb_lane u_lane (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (w_ctl[g]),
                .i_cfg  (w_cfg),
                .o_stat (w_stat[g])
            );
        end else begin : g_absent
            assign w_stat[g] = '0;
        end
    end

    // request outcome
    always_comb begin
        unique case (w_op)
            rstb_pkg::REQ_TICK,
            rstb_pkg::REQ_STOP,
            rstb_pkg::REQ_DAILY:  w_ok = 1'b1;
            rstb_pkg::REQ_ON,
            rstb_pkg::REQ_TOGGLE: w_ok = w_idx_in_cnt && w_stat[r_in.relay_index].ok;
            rstb_pkg::REQ_OFF,
            rstb_pkg::REQ_QUERY:  w_ok = w_idx_in_cnt;
            rstb_pkg::REQ_CLEAR:  w_ok = w_idx_exists;
            default:              w_ok = 1'b0;
        endcase
    end

    // response assembly
    always_comb begin
        for (int k = 0; k < NR; k++) begin
            w_onm[k] = w_stat[k].on;
            w_lkm[k] = w_stat[k].locked;
        end
        n_out.accepted          = w_ok;
        n_out.relay_on_mask     = w_onm;
        n_out.pin_mask          = (w_onm ^ r_active_low) & w_vmask;
        n_out.lockout_mask      = w_lkm;
        n_out.lock_code         = w_stat[r_in.relay_index].cause;
        n_out.switch_on_count   = w_stat[r_in.relay_index].act;
        n_out.on_time_today_sec = w_stat[r_in.relay_index].on_sec;
    end

    // stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in <= i_req.payload;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // backpressure only when both stages are full and the receiver stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_out_valid && !o_rsp.ready))
        else $error("input stalled without a full pipeline");

    // an accepted turn-on shows the relay on in its response
    a_on_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_op == rstb_pkg::REQ_ON && w_ok)
        |=> r_out.relay_on_mask[$past(r_in.relay_index)])
        else $error("accepted turn-on not reflected");

    // stop all leaves no counted relay on
    a_stop_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_op == rstb_pkg::REQ_STOP)
        |=> ((r_out.relay_on_mask & $past(w_cnt_mask)) == 4'd0))
        else $error("relay left on after stop all");

endmodule
